// File: design/scpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpc_pkg
// Shared types and constants of the servo command and PWM controller core.
// ----------------------------------------------------------------------------
package scpc_pkg;

    // event kinds carried in s_tuser
    typedef logic [1:0] func_t;
    localparam func_t FUNC_CMD   = 2'd0;
    localparam func_t FUNC_READY = 2'd1;
    localparam func_t FUNC_TICK  = 2'd2;
    localparam func_t FUNC_START = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_DUTY_MARGIN = 3'd0;
    localparam cfg_idx_t REG_DUTY_STEP   = 3'd1;
    localparam cfg_idx_t REG_GAIN_SHIFT  = 3'd2;
    localparam cfg_idx_t REG_DUTY_CENTER = 3'd3;

    localparam int CFG_DATA_BITS = 12;

    // register reset values
    localparam logic [10:0] MARGIN_RESET = 11'd100;
    localparam logic [10:0] STEP_RESET   = 11'd100;
    localparam logic [3:0]  SHIFT_RESET  = 4'd4;
    localparam logic [11:0] CENTER_RESET = 12'd2047;
    localparam int          DUTY_MID     = 2047;

    // command characters, upper case
    localparam logic [7:0] CMD_UP     = 8'h55; // U
    localparam logic [7:0] CMD_DOWN   = 8'h44; // D
    localparam logic [7:0] CMD_PLUS   = 8'h50; // P
    localparam logic [7:0] CMD_MINUS  = 8'h4D; // M
    localparam logic [7:0] CMD_CLEAR  = 8'h43; // C
    localparam logic [7:0] CMD_FREE   = 8'h46; // F
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    // input word fields
    typedef struct packed {
        logic signed [15:0] error_delta;
        logic signed [15:0] position_error;
        logic [7:0]         cmd_byte;
    } in_word_t;

endpackage

// File: design/servo_command_pwm_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_command_pwm_controller_core
// Command decoder, duty clamp and PD control law for a complementary PWM pair.
// ----------------------------------------------------------------------------
// a word is held in the input register, then its result word in the output reg
// throughput: one word per cycle unless m_tready stalls, set by the input and
//   output register each holding one word; state is updated as a word enters it
// reset: synchronous active-low aresetn clears the pipeline valids, the duty to
//   mid scale, increment, gate and loop flag, and loads register defaults
module servo_command_pwm_controller_core
    import scpc_pkg::*;
#(
    parameter int DUTY_BITS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // command word
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cmd_byte, position_error, error_delta
    input  logic [39:0]                     s_tdata,
    // func
    input  logic [1:0]                      s_tuser,
    // result word
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // duty_a, duty_b, step_increment, accepted, mailbox_write, mailbox_byte,
    // encoder_clear, control_on, zero fill
    output logic [((2*DUTY_BITS+20+7)/8)*8-1:0] m_tdata,
    // configuration
    input  logic                            cfg_we,
    input  logic [CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        cfg_wdata
);

    localparam int OUT_BITS = 2 * DUTY_BITS + 20;
    localparam int M_W      = ((OUT_BITS + 7) / 8) * 8;
    localparam int CW       = 34;
    localparam logic signed [CW-1:0] FULL_S = CW'((64'(1) << DUTY_BITS) - 64'(1));
    localparam logic [DUTY_BITS-1:0] FULL_D = DUTY_BITS'((64'(1) << DUTY_BITS) - 64'(1));
    localparam logic [DUTY_BITS-1:0] DUTY_RESET =
        (DUTY_MID > (2 ** DUTY_BITS) - 1) ? FULL_D : DUTY_BITS'(DUTY_MID);

    // configuration registers
    logic [10:0] margin_reg;
    logic [10:0] step_reg;
    logic [3:0]  shift_reg;
    logic [11:0] center_reg;

    // block state
    logic [DUTY_BITS-1:0] duty_reg,  duty_next;
    logic [7:0]           incr_reg,  incr_next;
    logic                 gate_reg,  gate_next;
    logic                 loop_reg,  loop_next;

    // input stage
    logic     in_valid_reg;
    func_t    in_func_reg;
    in_word_t in_word_reg;

    // output stage
    logic           out_valid_reg;
    logic [M_W-1:0] out_data_reg, out_data_next;

    logic advance;
    logic acc_next, enc_next;

    logic [7:0]              cmd_up;
    logic signed [CW-1:0]    margin_s, bound_hi, bound_lo;
    logic signed [CW-1:0]    duty_s, step_s, center_s;
    logic signed [16:0]      err_sum;
    logic signed [CW-1:0]    law_val;
    logic signed [CW-1:0]    pm_val, pm_lim;
    logic signed [CW-1:0]    tick_lim;

    function automatic logic [DUTY_BITS-1:0] sat_full(input logic signed [CW-1:0] v);
        logic [DUTY_BITS-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > FULL_S) begin
            r = FULL_D;
        end else begin
            r = v[DUTY_BITS-1:0];
        end
        return r;
    endfunction

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= MARGIN_RESET;
            step_reg   <= STEP_RESET;
            shift_reg  <= SHIFT_RESET;
            center_reg <= CENTER_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DUTY_MARGIN: margin_reg <= cfg_wdata[10:0];
                REG_DUTY_STEP:   step_reg   <= cfg_wdata[10:0];
                REG_GAIN_SHIFT:  shift_reg  <= cfg_wdata[3:0];
                REG_DUTY_CENTER: center_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg <= s_tuser;
            in_word_reg <= s_tdata;
        end
    end

    // shared bounds
    assign margin_s = $signed({{(CW-11){1'b0}}, margin_reg});
    assign bound_hi = FULL_S - margin_s;
    assign bound_lo = margin_s;
    assign duty_s   = $signed({{(CW-DUTY_BITS){1'b0}}, duty_reg});
    assign step_s   = $signed({{(CW-11){1'b0}}, step_reg});
    assign center_s = $signed({{(CW-12){1'b0}}, center_reg});

    assign cmd_up = (in_word_reg.cmd_byte >= CHAR_LOW_A && in_word_reg.cmd_byte <= CHAR_LOW_Z)
                  ? in_word_reg.cmd_byte - CASE_DIFF : in_word_reg.cmd_byte;

    // P lowers, M raises; lower bound wins when bounds cross
    always_comb begin
        pm_val = (cmd_up == CMD_PLUS) ? duty_s - step_s : duty_s + step_s;
        pm_lim = (pm_val > bound_hi) ? bound_hi : pm_val;
        if (pm_lim < bound_lo) begin
            pm_lim = bound_lo;
        end
    end

    // PD law; upper bound wins when bounds cross
    always_comb begin
        err_sum  = 17'(in_word_reg.position_error) + 17'(in_word_reg.error_delta);
        law_val  = (CW'(err_sum) <<< shift_reg) + center_s;
        if (law_val > bound_hi) begin
            tick_lim = bound_hi;
        end else if (law_val < bound_lo) begin
            tick_lim = bound_lo;
        end else begin
            tick_lim = law_val;
        end
    end

    always_comb begin
        duty_next = duty_reg;
        incr_next = incr_reg;
        gate_next = gate_reg;
        loop_next = loop_reg;
        acc_next  = 1'b0;
        enc_next  = 1'b0;
        unique case (in_func_reg)
            FUNC_CMD: begin
                if (gate_reg) begin
                    acc_next  = 1'b1;
                    gate_next = 1'b0;
                    case (cmd_up)
                        CMD_UP:    incr_next = incr_reg - 8'd1;
                        CMD_DOWN:  incr_next = incr_reg + 8'd1;
                        CMD_PLUS, CMD_MINUS: duty_next = sat_full(pm_lim);
                        CMD_CLEAR: begin
                            incr_next = '0;
                            loop_next = 1'b1;
                            enc_next  = 1'b1;
                        end
                        CMD_FREE: begin
                            loop_next = 1'b0;
                            duty_next = sat_full(center_s);
                        end
                        default: ;
                    endcase
                end
            end
            FUNC_READY: gate_next = 1'b1;
            FUNC_TICK: begin
                if (loop_reg) begin
                    duty_next = sat_full(tick_lim);
                end
            end
            FUNC_START: begin
                incr_next = '0;
                gate_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        out_data_next = '0;
        out_data_next[OUT_BITS-1:0] = {loop_next,
                                       enc_next,
                                       acc_next ? in_word_reg.cmd_byte : 8'd0,
                                       acc_next,
                                       acc_next,
                                       incr_next,
                                       FULL_D - duty_next,
                                       duty_next};
    end

    // state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            duty_reg      <= DUTY_RESET;
            incr_reg      <= '0;
            gate_reg      <= 1'b0;
            loop_reg      <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                duty_reg <= duty_next;
                incr_reg <= incr_next;
                gate_reg <= gate_next;
                loop_reg <= loop_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for servo_command_pwm_controller_core. Events go in on
// the slave stream and a local model of the duty, increment, gate and loop
// flag predicts each status word. Every status word that comes back is checked
// field by field. Both stream sides idle at random. The run covers the
// directed command, gate and tick cases first, then random traffic under
// several register settings.
// ----------------------------------------------------------------------------
module tb;
    import scpc_pkg::*;

    localparam int  DUTY_BITS  = 12;
    localparam int  RES_BITS   = ((2*DUTY_BITS+20+7)/8)*8;
    localparam int  FULL_SCALE = (1 << DUTY_BITS) - 1;
    localparam int  CYCLE_LIMIT = 200000;

    // status word as laid out on m_tdata, msb first
    typedef struct packed {
        logic [3:0]         pad;
        logic               ctl_on;
        logic               enc_clear;
        logic [7:0]         mbx_byte;
        logic               mbx_write;
        logic               accepted;
        logic signed [7:0]  step_inc;
        logic [11:0]        duty_b;
        logic [11:0]        duty_a;
    } status_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [39:0]              s_tdata = '0;
    logic [1:0]               s_tuser = FUNC_CMD;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [RES_BITS-1:0]      m_tdata;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = REG_DUTY_MARGIN;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    // model of the block state and registers
    logic [11:0] mdl_duty   = 12'(DUTY_MID);
    logic [7:0]  mdl_inc    = '0;
    logic        mdl_gate   = 1'b0;
    logic        mdl_loop   = 1'b0;
    logic [10:0] mdl_margin = MARGIN_RESET;
    logic [10:0] mdl_step   = STEP_RESET;
    logic [3:0]  mdl_shift  = SHIFT_RESET;
    logic [11:0] mdl_center = CENTER_RESET;

    status_t status_due[$];
    int      mismatches = 0;
    int      cycles = 0;
    int      send_gap_pct = 16;
    int      recv_stall_pct = 70;

    logic [7:0] command_set[6] = '{CMD_UP, CMD_DOWN, CMD_PLUS, CMD_MINUS, CMD_CLEAR,
                                   CMD_FREE};

    servo_command_pwm_controller_core #(
        .DUTY_BITS(DUTY_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [11:0] saturate_duty(longint v);
        if (v < 0) return '0;
        if (v > FULL_SCALE) return 12'(FULL_SCALE);
        return 12'(v);
    endfunction

    // P/M: lower bound applied last; tick: upper bound takes precedence
    function automatic logic [11:0] clamp_duty(longint v, bit low_bound_wins);
        longint top;
        longint bottom;
        top    = longint'(FULL_SCALE) - longint'(mdl_margin);
        bottom = longint'(mdl_margin);
        if (low_bound_wins) begin
            if (v > top) v = top;
            if (v < bottom) v = bottom;
        end else begin
            if (v > top) v = top;
            else if (v < bottom) v = bottom;
        end
        return saturate_duty(v);
    endfunction

    function automatic status_t advance_servo(func_t f, in_word_t w);
        status_t    r;
        logic [7:0] up;
        longint     v;
        r = '0;
        case (f)
            FUNC_CMD: begin
                if (mdl_gate) begin
                    up = (w.cmd_byte >= CHAR_LOW_A && w.cmd_byte <= CHAR_LOW_Z) ?
                         w.cmd_byte - CASE_DIFF : w.cmd_byte;
                    r.accepted  = 1'b1;
                    r.mbx_write = 1'b1;
                    r.mbx_byte  = w.cmd_byte;
                    mdl_gate    = 1'b0;
                    case (up)
                        CMD_UP:    mdl_inc = mdl_inc - 8'd1;
                        CMD_DOWN:  mdl_inc = mdl_inc + 8'd1;
                        CMD_PLUS:  mdl_duty = clamp_duty(longint'(mdl_duty)
                                                         - longint'(mdl_step), 1'b1);
                        CMD_MINUS: mdl_duty = clamp_duty(longint'(mdl_duty)
                                                         + longint'(mdl_step), 1'b1);
                        CMD_CLEAR: begin
                            mdl_inc     = '0;
                            mdl_loop    = 1'b1;
                            r.enc_clear = 1'b1;
                        end
                        CMD_FREE: begin
                            mdl_loop = 1'b0;
                            mdl_duty = saturate_duty(longint'(mdl_center));
                        end
                        default: ;
                    endcase
                end
            end
            FUNC_READY: mdl_gate = 1'b1;
            FUNC_TICK: begin
                if (mdl_loop) begin
                    v = (longint'(w.position_error) <<< mdl_shift)
                        + (longint'(w.error_delta) <<< mdl_shift)
                        + longint'(mdl_center);
                    mdl_duty = clamp_duty(v, 1'b0);
                end
            end
            default: begin
                mdl_inc  = '0;
                mdl_gate = 1'b1;
            end
        endcase
        r.duty_a   = mdl_duty;
        r.duty_b   = 12'(FULL_SCALE) - mdl_duty;
        r.step_inc = mdl_inc;
        r.ctl_on   = mdl_loop;
        return r;
    endfunction

    task automatic report(string what, longint want, longint got);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        mismatches++;
    endtask

    task automatic check_status(status_t got);
        status_t want;
        if (status_due.size() == 0) begin
            $display("%0t: unexpected word: expected none, actual %h", $time, got);
            mismatches++;
        end else begin
            want = status_due.pop_front();
            if (got.duty_a !== want.duty_a) report("duty_a", want.duty_a, got.duty_a);
            if (got.duty_b !== want.duty_b) report("duty_b", want.duty_b, got.duty_b);
            if (got.step_inc !== want.step_inc)
                report("step_increment", want.step_inc, got.step_inc);
            if (got.accepted !== want.accepted)
                report("accepted", want.accepted, got.accepted);
            if (got.mbx_write !== want.mbx_write)
                report("mailbox_write", want.mbx_write, got.mbx_write);
            if (got.mbx_byte !== want.mbx_byte)
                report("mailbox_byte", want.mbx_byte, got.mbx_byte);
            if (got.enc_clear !== want.enc_clear)
                report("encoder_clear", want.enc_clear, got.enc_clear);
            if (got.ctl_on !== want.ctl_on) report("control_on", want.ctl_on, got.ctl_on);
            if (got.pad !== want.pad) report("zero fill", want.pad, got.pad);
        end
    endtask

    // receiver stalls and result checking
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) check_status(status_t'(m_tdata));
    end

    // s_tvalid is left high after acceptance; callers that stop sending lower it
    task automatic send_word(func_t f, logic [7:0] cmd, logic signed [15:0] pos_err,
                             logic signed [15:0] err_delta);
        in_word_t w;
        w.cmd_byte       = cmd;
        w.position_error = pos_err;
        w.error_delta    = err_delta;
        if ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= f;
        do @(posedge aclk); while (!s_tready);
        status_due.push_back(advance_servo(f, w));
    endtask

    task automatic send_event(func_t f);
        send_word(f, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_command(logic [7:0] cmd);
        send_word(FUNC_CMD, cmd, 16'($urandom), 16'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_DUTY_MARGIN: mdl_margin = value[10:0];
            REG_DUTY_STEP:   mdl_step   = value[10:0];
            REG_GAIN_SHIFT:  mdl_shift  = value[3:0];
            REG_DUTY_CENTER: mdl_center = value;
            default: ;
        endcase
    endtask

    // includes a write to an index past the register list, which must be ignored
    task automatic set_config(logic [10:0] margin, logic [10:0] step, logic [3:0] shift,
                              logic [11:0] center);
        write_reg(REG_DUTY_MARGIN, 12'(margin));
        write_reg(REG_DUTY_STEP, 12'(step));
        write_reg(REG_GAIN_SHIFT, 12'(shift));
        write_reg(REG_DUTY_CENTER, center);
        write_reg(cfg_idx_t'($urandom_range(REG_DUTY_CENTER + 1, (1 << CFG_IDX_BITS) - 1)),
                  CFG_DATA_BITS'($urandom));
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_command();
        logic [7:0] c;
        if ($urandom_range(99) < 15) return 8'($urandom);
        c = command_set[$urandom_range(5)];
        return $urandom_range(1) ? (c | CASE_DIFF) : c;
    endfunction

    function automatic logic signed [15:0] pick_error();
        if ($urandom_range(1)) return 16'($signed($urandom_range(120)) - 60);
        return 16'($urandom);
    endfunction

    task automatic test_gate_closed();
        send_command(CMD_UP);
        send_event(FUNC_TICK);
    endtask

    task automatic test_commands();
        send_event(FUNC_START);
        send_command(CMD_UP);
        send_event(FUNC_READY);
        send_command(CMD_UP | CASE_DIFF);
        send_event(FUNC_READY);
        send_command(CMD_DOWN);
        send_event(FUNC_READY);
        send_command(CMD_PLUS);
        send_event(FUNC_READY);
        send_command(CMD_MINUS | CASE_DIFF);
        send_event(FUNC_READY);
        send_command(8'hFF);
        send_event(FUNC_READY);
        send_command(8'h00);
        // gate closed again: not accepted
        send_command(CMD_DOWN | CASE_DIFF);
        send_event(FUNC_START);
    endtask

    task automatic test_control_ticks();
        send_event(FUNC_READY);
        send_command(CMD_CLEAR | CASE_DIFF);
        send_word(FUNC_TICK, 8'($urandom), 16'sh7FFF, 16'sh7FFF);
        send_word(FUNC_TICK, 8'($urandom), 16'sh8000, 16'sh8000);
        send_word(FUNC_TICK, 8'($urandom), 16'sd3, -16'sd1);
        send_event(FUNC_READY);
        send_command(CMD_FREE);
        send_event(FUNC_TICK);
    endtask

    task automatic test_random_traffic(int n_items);
        int sent;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                send_event(($urandom_range(3) == 0) ? FUNC_START : FUNC_READY);
                send_command(pick_command());
                sent += 2;
            end else if (pick < 75) begin
                send_word(FUNC_TICK, 8'($urandom), pick_error(), pick_error());
                sent++;
            end else if (pick < 87) begin
                send_command(pick_command());
                sent++;
            end else begin
                send_event(($urandom_range(1) == 0) ? FUNC_START : FUNC_READY);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_gate_closed();
        test_commands();
        test_control_ticks();
        wait_drained();

        set_config(11'($urandom_range(400)), 11'($urandom_range(1, 600)),
                   4'($urandom_range(8)), 12'($urandom_range(4095)));
        test_random_traffic(100);
        wait_drained();

        send_gap_pct   = 70;
        recv_stall_pct = 16;
        set_config(11'd2047, 11'd2047, 4'd8, 12'd4095);
        test_random_traffic(100);
        wait_drained();

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        set_config(11'd0, 11'd0, 4'd0, 12'd0);
        test_random_traffic(100);
        wait_drained();

        set_config(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                   4'($urandom_range(8)), 12'($urandom_range(4095)));
        test_random_traffic(100);
        wait_drained();

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
